[design/vel_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the visual error to lean command block.
// Used by the register file, controller, datapath and top level.
package vel_pkg;

   // Register map, index of each configuration register
   localparam logic [2:0] REG_TILT_LIMIT    = 3'd0;
   localparam logic [2:0] REG_LEVEL_LIMIT   = 3'd1;
   localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd2;
   localparam logic [2:0] REG_HEIGHT_SCALE  = 3'd3;
   localparam logic [2:0] REG_GAIN          = 3'd4;
   localparam logic [2:0] REG_MAX_ANGLE     = 3'd5;

   localparam int CSR_ADDR_WIDTH = 5;

   // Reset values of the registers
   localparam logic [14:0] RST_TILT_LIMIT    = 15'd6472;
   localparam logic [14:0] RST_LEVEL_LIMIT   = 15'd715;
   localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd300;
   localparam logic [15:0] RST_HEIGHT_SCALE  = 16'd145;
   localparam logic [7:0]  RST_GAIN          = 8'd2;
   localparam logic [10:0] RST_MAX_ANGLE     = 11'd133;

   // Message characters
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;

   // Operand selection codes of the shared multiplier
   typedef logic [1:0] mul_op_type;
   localparam mul_op_type MUL_OP_HS = 2'd0;  // height * scale
   localparam mul_op_type MUL_OP_KG = 2'd1;  // (height * scale) * gain
   localparam mul_op_type MUL_OP_X  = 2'd2;  // x error * k
   localparam mul_op_type MUL_OP_Y  = 2'd3;  // negated y error * k

   typedef struct packed {
      logic [7:0]         presence_char;
      logic [7:0]         x_sign_char;
      logic [23:0]        x_digit_chars;
      logic [7:0]         y_sign_char;
      logic [23:0]        y_digit_chars;
      logic [11:0]        height_cm;
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] target_roll_cmd;
      logic signed [15:0] target_pitch_cmd;
      logic               object_seen;
      logic               shutdown_request;
      logic signed [15:0] x_error_pixels;
      logic signed [15:0] y_error_pixels;
   } rsp_data_type;

   typedef struct packed {
      logic [14:0] tilt_limit;
      logic [14:0] level_limit;
      logic [15:0] timeout_ticks;
      logic [15:0] height_scale;
      logic [7:0]  gain;
      logic [10:0] max_angle;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load_item;
      logic       mul_en;
      mul_op_type mul_op;
      logic       save_roll;
      logic       load_rsp;
   } cmd_type;

endpackage

[design/vel_csr.sv]
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on vel_pkg for the register map, reset values and cfg_type.
module vel_csr
   import vel_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index      = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_TILT_LIMIT:    cfg_in.tilt_limit    = csr_pwdata[14:0];
            REG_LEVEL_LIMIT:   cfg_in.level_limit   = csr_pwdata[14:0];
            REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_pwdata[15:0];
            REG_HEIGHT_SCALE:  cfg_in.height_scale  = csr_pwdata[15:0];
            REG_GAIN:          cfg_in.gain          = csr_pwdata[7:0];
            REG_MAX_ANGLE:     cfg_in.max_angle     = csr_pwdata[10:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_TILT_LIMIT:    csr_prdata = {17'd0, cfg_ff.tilt_limit};
         REG_LEVEL_LIMIT:   csr_prdata = {17'd0, cfg_ff.level_limit};
         REG_TIMEOUT_TICKS: csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         REG_HEIGHT_SCALE:  csr_prdata = {16'd0, cfg_ff.height_scale};
         REG_GAIN:          csr_prdata = {24'd0, cfg_ff.gain};
         REG_MAX_ANGLE:     csr_prdata = {21'd0, cfg_ff.max_angle};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tilt_limit    <= RST_TILT_LIMIT;
         cfg_ff.level_limit   <= RST_LEVEL_LIMIT;
         cfg_ff.timeout_ticks <= RST_TIMEOUT_TICKS;
         cfg_ff.height_scale  <= RST_HEIGHT_SCALE;
         cfg_ff.gain          <= RST_GAIN;
         cfg_ff.max_angle     <= RST_MAX_ANGLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/vel_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing controller: input handshake, multiplier schedule, result valid.
// Depends on vel_pkg for cmd_type and the multiplier codes.
module vel_ctrl
   import vel_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HS   = 3'd1;
   localparam logic [2:0] ST_KG   = 3'd2;
   localparam logic [2:0] ST_MX   = 3'd3;
   localparam logic [2:0] ST_MY   = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.mul_op   = MUL_OP_HS;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_HS;
            end
         end
         ST_HS: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_OP_HS;
            state_in   = ST_KG;
         end
         ST_KG: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_OP_KG;
            state_in   = ST_MX;
         end
         ST_MX: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_OP_X;
            state_in   = ST_MY;
         end
         ST_MY: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_op    = MUL_OP_Y;
            cmd.save_roll = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/vel_dp.sv]
`timescale 1ns / 1ps
// Datapath: message decode, tilt counter, shared multiplier, clamp, result register.
// Depends on vel_pkg for payload, configuration and command types.
module vel_dp
   import vel_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  cmd_type      cmd,
   input  req_data_type req_data,
   output rsp_data_type rsp_data
);

   function automatic logic signed [15:0] decode_axis(input logic [7:0]  sgn,
                                                      input logic [23:0] dig);
      logic signed [15:0] h;
      logic signed [15:0] t;
      logic signed [15:0] o;
      logic signed [15:0] e;
      h = signed'({8'd0, dig[23:16]}) - 16'sd48;
      t = signed'({8'd0, dig[15:8]}) - 16'sd48;
      o = signed'({8'd0, dig[7:0]}) - 16'sd48;
      e = h * 16'sd100 + t * 16'sd10 + o;
      if (sgn == CHAR_ONE) begin
         e = -e;
      end
      return e;
   endfunction

   function automatic logic [16:0] abs_angle(input logic signed [15:0] v);
      logic [16:0] ext;
      ext = {v[15], v};
      return ext[16] ? (~ext + 17'd1) : ext;
   endfunction

   // shift right 12 (floor), then limit to +-max_angle*16
   function automatic logic signed [15:0] clamp_cmd(input logic signed [52:0] p,
                                                    input logic [10:0]        max_a);
      logic signed [40:0] q;
      logic signed [40:0] lim;
      logic signed [40:0] nlim;
      logic signed [15:0] r;
      q    = signed'(p[52:12]);
      lim  = signed'({26'd0, max_a, 4'd0});
      nlim = -lim;
      if (q > lim) begin
         r = signed'(lim[15:0]);
      end else if (q < nlim) begin
         r = signed'(nlim[15:0]);
      end else begin
         r = signed'(q[15:0]);
      end
      return r;
   endfunction

   logic [15:0]        tilt_count_ff, tilt_count_in;
   logic [11:0]        height_ff;
   logic signed [15:0] ex_ff, ey_ff;
   logic               seen_ff, cmd_en_ff, shut_ff;
   logic [35:0]        k_ff;
   logic signed [52:0] p_ff;
   logic signed [15:0] rc_ff;
   rsp_data_type       rsp_data_ff;

   logic               seen, tilted, level, shut;
   logic [16:0]        ar, ap;
   logic signed [16:0] mul_a;
   logic signed [36:0] mul_b;
   logic signed [53:0] prod;
   logic signed [15:0] pc;

   // decode and tilt tracking on the accepted item
   assign seen   = (req_data.presence_char != CHAR_ZERO);
   assign ar     = abs_angle(req_data.roll_angle);
   assign ap     = abs_angle(req_data.pitch_angle);
   assign tilted = (ar >= {2'b0, cfg.tilt_limit}) || (ap >= {2'b0, cfg.tilt_limit});
   assign level  = (ar < {2'b0, cfg.level_limit}) && (ap < {2'b0, cfg.level_limit});

   always_comb begin
      if (tilted) begin
         tilt_count_in = (tilt_count_ff == 16'hFFFF) ? tilt_count_ff : tilt_count_ff + 16'd1;
      end else begin
         tilt_count_in = 16'd0;
      end
      shut = tilted && (tilt_count_in >= cfg.timeout_ticks);
   end

   // shared multiplier operand selection
   always_comb begin
      case (cmd.mul_op)
         MUL_OP_HS: begin
            mul_a = signed'({5'd0, height_ff});
            mul_b = signed'({21'd0, cfg.height_scale});
         end
         MUL_OP_KG: begin
            mul_a = signed'({9'd0, cfg.gain});
            mul_b = signed'({1'b0, k_ff});
         end
         MUL_OP_X: begin
            mul_a = {ex_ff[15], ex_ff};
            mul_b = signed'({1'b0, k_ff});
         end
         MUL_OP_Y: begin
            mul_a = -{ey_ff[15], ey_ff};
            mul_b = signed'({1'b0, k_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;
   assign pc   = clamp_cmd(p_ff, cfg.max_angle);

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_count_ff <= 16'd0;
      end else if (cmd.load_item) begin
         tilt_count_ff <= tilt_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         height_ff <= req_data.height_cm;
         seen_ff   <= seen;
         cmd_en_ff <= seen && level;
         shut_ff   <= shut;
         ex_ff     <= seen ? decode_axis(req_data.x_sign_char, req_data.x_digit_chars)
                           : 16'sd0;
         ey_ff     <= seen ? decode_axis(req_data.y_sign_char, req_data.y_digit_chars)
                           : 16'sd0;
      end
      if (cmd.mul_en) begin
         if (cmd.mul_op inside {MUL_OP_HS, MUL_OP_KG}) begin
            k_ff <= prod[35:0];
         end else begin
            p_ff <= prod[52:0];
         end
      end
      if (cmd.save_roll) begin
         rc_ff <= pc;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.target_roll_cmd  <= cmd_en_ff ? rc_ff : 16'sd0;
         rsp_data_ff.target_pitch_cmd <= cmd_en_ff ? pc : 16'sd0;
         rsp_data_ff.object_seen      <= seen_ff;
         rsp_data_ff.shutdown_request <= shut_ff;
         rsp_data_ff.x_error_pixels   <= ex_ff;
         rsp_data_ff.y_error_pixels   <= ey_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

[design/visual_error_to_lean_command_unit.sv]
`timescale 1ns / 1ps
// Top level of the visual error to lean command block.
// Instantiates vel_csr, vel_ctrl and vel_dp; types come from vel_pkg.
//
//   channel  ports                         direction  moves
//   req      req_valid/req_stall/req_data  in         one tracking message per transfer
//   rsp      rsp_valid/rsp_stall/rsp_data  out        one lean command result per transfer
//   csr      csr_p*                        in/out     APB-style register access
//
// Sequence: an item is taken in the idle state, then the one shared multiplier
// runs four passes (height*scale, *gain, *x error, *y error) and the clamp
// feeds the result register; no new item is taken until the block is idle again.
// Reset: synchronous, active high; clears the sequencer, result valid, the
// tilt counter and restores the register reset values.
// Stalls: the result register holds while rsp_stall is high; the next
// transfer on req is still taken and runs up to the result load.
module visual_error_to_lean_command_unit
   import vel_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_data_type              req_data,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_data_type              rsp_data,
   // configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   cfg_type cfg;
   cmd_type cmd;

   // register file, to be written only while idle; the block does not enforce this
   vel_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: steps the multiplier passes and owns both handshakes
   vel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // decode, tilt counter, multiply, clamp and result register
   vel_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for visual_error_to_lean_command_unit: directed and random
// tracking messages, several register settings, checked against an in-bench predictor.
// Depends on vel_pkg and the RTL only.
module tb
   import vel_pkg::*;
();

   localparam int HANG_LIMIT = 2000;  // cycles with no transfer before giving up

   typedef struct packed {
      req_data_type msg;
      logic         typed;   // want below holds the expected result
      rsp_data_type want;
   } script_row_type;

   localparam rsp_data_type NO_CHECK = '0;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   req_data_type              req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   rsp_data_type              rsp_data;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [31:0]               csr_pwdata  = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   visual_error_to_lean_command_unit dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mirror of the register file and the tilt counter
   logic [14:0] cfg_tilt    = RST_TILT_LIMIT;
   logic [14:0] cfg_level   = RST_LEVEL_LIMIT;
   logic [15:0] cfg_timeout = RST_TIMEOUT_TICKS;
   logic [15:0] cfg_scale   = RST_HEIGHT_SCALE;
   logic [7:0]  cfg_gain    = RST_GAIN;
   logic [10:0] cfg_amax    = RST_MAX_ANGLE;
   logic [15:0] tilt_run    = '0;

   rsp_data_type   lean_due[$];   // expected results, oldest first
   script_row_type opening[$];

   bit steady = 1'b0;           // suppress idling on both sides
   int tilt_left = 0;           // remaining ticks of a tilted run
   int errors = 0, msgs_sent = 0, results_seen = 0, seen_count = 0, shut_count = 0;
   int settings_used = 1, quiet_cycles = 0;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Each byte counts as byte - '0', so non-digit bytes land outside 0..9.
   function automatic int pixel_error(input logic [7:0] sgn, input logic [23:0] dg);
      int e;
      e = (int'(dg[23:16]) - int'(CHAR_ZERO)) * 100
        + (int'(dg[15:8]) - int'(CHAR_ZERO)) * 10
        + int'(dg[7:0]) - int'(CHAR_ZERO);
      if (sgn == CHAR_ONE) e = -e;
      return e;
   endfunction

   // err * height * scale * gain, floor-shift by 12, clamp to +-16*max_angle
   function automatic logic signed [15:0] lean_cmd(input int err, input logic [11:0] h);
      longint p, lim;
      p = longint'(err) * longint'(h) * longint'(cfg_scale) * longint'(cfg_gain);
      p = p >>> 12;
      lim = longint'(cfg_amax) * 16;
      if (p > lim) p = lim;
      if (p < -lim) p = -lim;
      return p[15:0];
   endfunction

   // Advances the tilt counter as a side effect.
   function automatic rsp_data_type predict_lean(input req_data_type d);
      rsp_data_type r;
      int ar, ap, ex, ey;
      bit tilted;
      ar = d.roll_angle < 0 ? -int'(d.roll_angle) : int'(d.roll_angle);
      ap = d.pitch_angle < 0 ? -int'(d.pitch_angle) : int'(d.pitch_angle);
      tilted = ar >= int'(cfg_tilt) || ap >= int'(cfg_tilt);
      r = '0;
      if (tilted) begin
         if (tilt_run != 16'hFFFF) tilt_run++;
         r.shutdown_request = tilt_run >= cfg_timeout;
      end else begin
         tilt_run = '0;
      end
      if (d.presence_char != CHAR_ZERO) begin
         ex = pixel_error(d.x_sign_char, d.x_digit_chars);
         ey = pixel_error(d.y_sign_char, d.y_digit_chars);
         r.object_seen    = 1'b1;
         r.x_error_pixels = ex[15:0];
         r.y_error_pixels = ey[15:0];
         if (ar < int'(cfg_level) && ap < int'(cfg_level)) begin
            r.target_roll_cmd  = lean_cmd(ex, d.height_cm);
            r.target_pitch_cmd = lean_cmd(-ey, d.height_cm);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------

   function automatic logic [23:0] digits(input int n);
      return {CHAR_ZERO + 8'(n / 100), CHAR_ZERO + 8'((n / 10) % 10), CHAR_ZERO + 8'(n % 10)};
   endfunction

   function automatic req_data_type msg(input logic [7:0] pres, input logic [7:0] xs,
                                        input logic [23:0] xd, input logic [7:0] ys,
                                        input logic [23:0] yd, input int h,
                                        input int roll, input int pitch);
      return {pres, xs, xd, ys, yd, 12'(h), 16'(roll), 16'(pitch)};
   endfunction

   function automatic rsp_data_type res(input int rc, input int pc, input bit seen,
                                        input bit shut, input int ex, input int ey);
      return {16'(rc), 16'(pc), seen, shut, 16'(ex), 16'(ey)};
   endfunction

   function automatic logic signed [15:0] signed_angle(input int mag);
      return $urandom_range(1) ? 16'(-mag) : 16'(mag);
   endfunction

   // Sign byte and three digit bytes of one axis; mostly well-formed.
   function automatic logic [31:0] axis_chars();
      logic [7:0] sgn;
      int pick;
      pick = $urandom_range(99);
      sgn = pick < 45 ? CHAR_ZERO : pick < 90 ? CHAR_ONE : 8'($urandom);
      if ($urandom_range(99) < 85) return {sgn, digits($urandom_range(999))};
      return {sgn, 24'($urandom)};
   endfunction

   // Mostly level attitudes so commands get through, with runs of tilted
   // ticks to drive the timeout, boundary angles and plain noise.
   function automatic req_data_type rand_msg();
      req_data_type d;
      logic signed [15:0] hold;
      int pick;
      pick = $urandom_range(99);
      d.presence_char = pick < 15 ? CHAR_ZERO : pick < 85 ? CHAR_ONE : 8'($urandom);
      {d.x_sign_char, d.x_digit_chars} = axis_chars();
      {d.y_sign_char, d.y_digit_chars} = axis_chars();
      pick = $urandom_range(99);
      d.height_cm = pick < 50 ? 12'($urandom_range(255)) : pick < 90 ? 12'($urandom) :
                    pick < 95 ? 12'd0 : 12'hFFF;
      if (tilt_left == 0 && $urandom_range(99) < 5) tilt_left = $urandom_range(1, 12);
      if (tilt_left != 0) begin
         tilt_left--;
         d.roll_angle  = $urandom_range(9) == 0 ? 16'sh8000 :
                         signed_angle($urandom_range(cfg_tilt, 32767));
         d.pitch_angle = 16'($urandom);
         if ($urandom_range(1)) begin
            hold = d.roll_angle;
            d.roll_angle = d.pitch_angle;
            d.pitch_angle = hold;
         end
      end else begin
         pick = $urandom_range(99);
         if (pick < 60 && cfg_level != 0) begin
            d.roll_angle  = signed_angle($urandom_range(cfg_level - 1));
            d.pitch_angle = signed_angle($urandom_range(cfg_level - 1));
         end else if (pick < 80) begin
            // exactly on the level limit: not level
            d.roll_angle  = signed_angle(cfg_level);
            d.pitch_angle = signed_angle(cfg_level != 0 ? cfg_level - 1 : 0);
         end else begin
            d.roll_angle  = 16'($urandom);
            d.pitch_angle = 16'($urandom);
         end
      end
      return d;
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers
   // ---------------------------------------------------------------------

   // Present one message, hold it until the transfer, then log the expectation.
   task automatic send_msg(input req_data_type d, input bit typed, input rsp_data_type want);
      rsp_data_type pred;
      while (!steady && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      pred = predict_lean(d);
      lean_due.push_back(typed ? want : pred);
      msgs_sent++;
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (lean_due.size() != 0) @(posedge clock);
   endtask

   // Write all six registers back to back while the block is idle.
   task automatic apply_settings(input logic [31:0] tilt, input logic [31:0] level,
                                 input logic [31:0] timeout, input logic [31:0] scale,
                                 input logic [31:0] k, input logic [31:0] amax);
      logic [31:0] vals [6];
      vals = '{tilt, level, timeout, scale, k, amax};
      drain();
      for (int i = REG_TILT_LIMIT; i <= REG_MAX_ANGLE; i++) begin
         // setup phase, then access phase until pready
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= CSR_ADDR_WIDTH'(i * 4);
         csr_pwdata  <= vals[i];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         case (3'(i))
            REG_TILT_LIMIT:    cfg_tilt    = vals[i][14:0];
            REG_LEVEL_LIMIT:   cfg_level   = vals[i][14:0];
            REG_TIMEOUT_TICKS: cfg_timeout = vals[i][15:0];
            REG_HEIGHT_SCALE:  cfg_scale   = vals[i][15:0];
            REG_GAIN:          cfg_gain    = vals[i][7:0];
            REG_MAX_ANGLE:     cfg_amax    = vals[i][10:0];
            default: ;
         endcase
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings_used++;
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   task automatic check_lean(input rsp_data_type got);
      rsp_data_type want;
      results_seen++;
      seen_count += got.object_seen;
      shut_count += got.shutdown_request;
      if (lean_due.size() == 0) begin
         $error("result transfer with no message outstanding");
         errors++;
         return;
      end
      want = lean_due.pop_front();
      if (got.target_roll_cmd !== want.target_roll_cmd) begin
         $error("target_roll_cmd: expected %0d, got %0d",
                want.target_roll_cmd, got.target_roll_cmd);
         errors++;
      end
      if (got.target_pitch_cmd !== want.target_pitch_cmd) begin
         $error("target_pitch_cmd: expected %0d, got %0d",
                want.target_pitch_cmd, got.target_pitch_cmd);
         errors++;
      end
      if (got.object_seen !== want.object_seen) begin
         $error("object_seen: expected %0d, got %0d", want.object_seen, got.object_seen);
         errors++;
      end
      if (got.shutdown_request !== want.shutdown_request) begin
         $error("shutdown_request: expected %0d, got %0d",
                want.shutdown_request, got.shutdown_request);
         errors++;
      end
      if (got.x_error_pixels !== want.x_error_pixels) begin
         $error("x_error_pixels: expected %0d, got %0d",
                want.x_error_pixels, got.x_error_pixels);
         errors++;
      end
      if (got.y_error_pixels !== want.y_error_pixels) begin
         $error("y_error_pixels: expected %0d, got %0d",
                want.y_error_pixels, got.y_error_pixels);
         errors++;
      end
   endtask

   // Take each result transfer, then pick a new random stall for the next edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_lean(rsp_data);
         rsp_stall <= !steady && ($urandom_range(99) < 38);
      end
   end

   // Watchdog: count cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      // Opening script at reset settings: clamp is +-2128, tilt at 6472, level below 715.
      // No object: everything zero, even with full digits and height.
      opening.push_back({msg(CHAR_ZERO, CHAR_ONE, digits(999), CHAR_ONE, digits(999),
                             4095, 0, 0), 1'b1, res(0, 0, 0, 0, 0, 0)});
      // Zero height: errors decoded, commands zero.
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(123), CHAR_ONE, digits(45),
                             0, 0, 0), 1'b1, res(0, 0, 1, 0, 123, -45)});
      // Non-digit bytes at both ends of the byte range.
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, 24'h000000, CHAR_ZERO, 24'hFFFFFF,
                             0, 0, 0), 1'b1, res(0, 0, 1, 0, -5328, 22977)});
      opening.push_back({msg(CHAR_ONE, CHAR_ONE, 24'h000000, CHAR_ONE, 24'hFFFFFF,
                             0, 0, 0), 1'b1, res(0, 0, 1, 0, 5328, -22977)});
      // Full error at full height clamps; pitch takes the negated Y error.
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(999), CHAR_ZERO, digits(999),
                             4095, 0, 0), 1'b1, res(2128, -2128, 1, 0, 999, 999)});
      opening.push_back({msg(CHAR_ONE, CHAR_ONE, digits(999), CHAR_ONE, digits(999),
                             4095, 0, 0), 1'b1, res(-2128, 2128, 1, 0, -999, -999)});
      // Shift floors toward minus infinity: -290 >> 12 is -1, +290 >> 12 is 0.
      opening.push_back({msg(CHAR_ONE, CHAR_ONE, digits(1), CHAR_ZERO, digits(1),
                             1, 0, 0), 1'b1, res(-1, -1, 1, 0, -1, 1)});
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(1), CHAR_ONE, digits(1),
                             1, 0, 0), 1'b1, res(0, 0, 1, 0, 1, -1)});
      // Level limit: just below passes, at the limit blocks commands.
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(57), CHAR_ZERO, digits(33),
                             100, 714, 0), 1'b0, NO_CHECK});
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(57), CHAR_ZERO, digits(33),
                             100, 715, 0), 1'b1, res(0, 0, 1, 0, 57, 33)});
      opening.push_back({msg(CHAR_ONE, CHAR_ONE, digits(57), CHAR_ZERO, digits(33),
                             100, 0, -715), 1'b1, res(0, 0, 1, 0, -57, 33)});
      opening.push_back({msg(CHAR_ONE, CHAR_ONE, digits(250), CHAR_ONE, digits(80),
                             300, -714, 700), 1'b0, NO_CHECK});
      // Tilt: most negative angle, most positive, just under, exactly at the limit.
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(10), CHAR_ZERO, digits(20),
                             50, -32768, 0), 1'b1, res(0, 0, 1, 0, 10, 20)});
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(10), CHAR_ZERO, digits(20),
                             50, 0, 32767), 1'b1, res(0, 0, 1, 0, 10, 20)});
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(10), CHAR_ZERO, digits(20),
                             50, 6471, 0), 1'b1, res(0, 0, 1, 0, 10, 20)});
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(10), CHAR_ZERO, digits(20),
                             50, 0, -6472), 1'b1, res(0, 0, 1, 0, 10, 20)});
      // Any presence byte but '0' counts as seen; any sign byte but '1' is positive.
      opening.push_back({msg(8'h41, 8'h2D, digits(50), 8'h5A, digits(7),
                             200, 3, -3), 1'b0, NO_CHECK});
      opening.push_back({msg(8'hFF, 8'h00, 24'h3A3A3A, 8'hFF, 24'h2F3039,
                             4095, -1, 1), 1'b0, NO_CHECK});
      // Tilted tick with no object.
      opening.push_back({msg(CHAR_ZERO, CHAR_ZERO, digits(5), CHAR_ZERO, digits(5),
                             10, -32768, -32768), 1'b1, res(0, 0, 0, 0, 0, 0)});
      opening.push_back({msg(CHAR_ONE, CHAR_ZERO, digits(321), CHAR_ONE, digits(210),
                             1234, 100, -200), 1'b0, NO_CHECK});
      opening.push_back({msg(CHAR_ONE, CHAR_ONE, digits(999), CHAR_ZERO, digits(0),
                             4095, 0, 0), 1'b0, NO_CHECK});

      // Hold reset once, at the start.
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_msg(opening[i].msg, opening[i].typed, opening[i].want);

      // Lower extremes: everything tilted, nothing level, shutdown on each tilted tick.
      apply_settings(0, 0, 1, 0, 0, 0);
      repeat (40) send_msg(rand_msg(), 1'b0, NO_CHECK);

      // Upper extremes: tilted only at full scale, almost everything level, widest clamp.
      apply_settings(32767, 32767, 65535, 65535, 255, 2047);
      repeat (60) send_msg(rand_msg(), 1'b0, NO_CHECK);

      // Reset settings again, with both sides running flat out.
      apply_settings(RST_TILT_LIMIT, RST_LEVEL_LIMIT, RST_TIMEOUT_TICKS,
                     RST_HEIGHT_SCALE, RST_GAIN, RST_MAX_ANGLE);
      steady = 1'b1;
      repeat (80) send_msg(rand_msg(), 1'b0, NO_CHECK);
      steady = 1'b0;

      // Random settings; short timeouts so tilted runs reach shutdown.
      repeat (6) begin
         apply_settings($urandom_range(300, 12000), $urandom_range(100, 9000),
                        $urandom_range(1, 10), $urandom_range(65535),
                        $urandom_range(255), $urandom_range(2047));
         repeat (85) send_msg(rand_msg(), 1'b0, NO_CHECK);
      end

      // Let the last results in, then watch briefly for strays.
      drain();
      repeat (20) @(posedge clock);

      $display("Ran %0d tracking messages under %0d register settings.",
               msgs_sent, settings_used);
      $display("Checked %0d results: %0d with an object, %0d with a shutdown request.",
               results_seen, seen_count, shut_count);
      if (errors == 0 && lean_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
design/vel_pkg.sv
design/vel_csr.sv
design/vel_ctrl.sv
design/vel_dp.sv
design/visual_error_to_lean_command_unit.sv
dv/tb.sv
